@@ hdl/pdw_pkg.sv @@
// ----------------------------------------------------------------------------
// pdw_pkg
// Shared widths, codes and defaults of the polyline path distance walker.
// ----------------------------------------------------------------------------
package pdw_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int DIST_W    = 40;   // distance fields, fixed point
  localparam int IDX_OUT_W = 10;   // reported point and block indices
  localparam int ROOT_W    = 40;   // result bits of the segment length root

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_COMPLETE   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LD_DIF  = 8'b0000_0010,
    S_LD_SQX  = 8'b0000_0100,
    S_LD_SQY  = 8'b0000_1000,
    S_LD_ROOT = 8'b0001_0000,
    S_WK_RD   = 8'b0010_0000,
    S_WK_EV   = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

endpackage

@@ hdl/polyline_path_distance_walker_core.sv @@
// ----------------------------------------------------------------------------
// polyline_path_distance_walker_core
// Walks a loaded polyline route by distance and reports its position.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one item: op, coordinates,
// ends_block and step_distance. Every item gives exactly one result item on
// the output channel (out_valid/out_ready): status, into_segment, on_block,
// total_covered, point_index, block_index and complete.
// Points, block marks and segment lengths live in on-chip memories with a
// registered read. A load writes its point and, unless it is the first
// point or the previous point ends a block, computes the previous segment
// length by a bit-serial square root of 40 iterations. An advance reads
// and then evaluates each table entry it steps over in turn. Start, error
// cases and unused ops go from idle straight to the finish state.
// One item is in work at a time; in_ready is high while the block is idle.
// The result sits in an output register, so the next item is taken while a
// result waits; a finished item holds in its last state until the output
// register is free. Reset empties the table and rewinds the walk; memory
// contents are not cleared, entries beyond the fill count are never used.
// ----------------------------------------------------------------------------
module polyline_path_distance_walker_core #(
  parameter int MAX_POINTS = pdw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pdw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pdw_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic signed [31:0]                coord_x,
  input  logic signed [31:0]                coord_y,
  input  logic                              ends_block,
  input  logic [pdw_pkg::DIST_W-1:0]        step_distance,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [pdw_pkg::DIST_W-1:0]        into_segment,
  output logic [pdw_pkg::DIST_W-1:0]        on_block,
  output logic [pdw_pkg::DIST_W-1:0]        total_covered,
  output logic [pdw_pkg::IDX_OUT_W-1:0]     point_index,
  output logic [pdw_pkg::IDX_OUT_W-1:0]     block_index,
  output logic                              complete
);
  import pdw_pkg::*;

  localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW     = $clog2(MAX_POINTS + 1);
  localparam int DW     = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DW;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
  localparam int RADL_W = 2 * ROOT_W;
  localparam int RADP_W = (RAD_W > RADL_W) ? RAD_W : RADL_W + 1;
  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER_W = $clog2(ROOT_W);
  localparam int PT_W   = 2 * COORD_BITS + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Memories: point entry is {x, y, block end mark}
  logic [PT_W-1:0]              pt_mem [MAX_POINTS-1:0];
  logic [DIST_W-1:0]            seg_mem[MAX_POINTS-1:0];

  logic [PT_W-1:0]              pt_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic                         mk_q;
  logic [DIST_W-1:0]            seg_q;

  state_t state;

  logic [NW-1:0]           n;
  logic [IW-1:0]           cp;
  logic [IDX_OUT_W-1:0]    cb;
  logic [DIST_W-1:0]       sp, bp, total;
  logic                    done;
  logic [DIST_W:0]         prog;
  status_t                 st;

  logic signed [COORD_BITS-1:0] xin, yin;
  logic                    need_len;
  logic [IW-1:0]           seg_wa;
  logic [DW-1:0]           dx, dy;
  logic [SQ_W-1:0]         sq_a;
  logic [RADL_W-1:0]       rad;
  logic                    ovf;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic [ITER_W-1:0]       iter;

  logic                    accept, pt_we, seg_we;
  logic [NW-1:0]           n_dec;
  logic [IW-1:0]           rd_addr;
  logic [DIST_W-1:0]       seg_wd;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pt_we    = accept && (op == OP_LOAD) && (n < NW'(MAX_POINTS));
  assign n_dec    = n - NW'(1);
  assign rd_addr  = (state == S_IDLE) ? n_dec[IW-1:0] : cp;
  assign seg_we   = (state == S_LD_ROOT) && (iter == ITER_W'(ROOT_W - 1));

  assign x_q  = pt_q[PT_W-1:COORD_BITS+1];
  assign y_q  = pt_q[COORD_BITS:1];
  assign mk_q = pt_q[0];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[n[IW-1:0]] <= {coord_x[COORD_BITS-1:0], coord_y[COORD_BITS-1:0], ends_block};
    end
    pt_q <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_q <= seg_mem[rd_addr];
  end

  // Difference of coordinates, absolute value
  logic signed [DW-1:0] dfx, dfy;
  assign dfx = {xin[COORD_BITS-1], xin} - {x_q[COORD_BITS-1], x_q};
  assign dfy = {yin[COORD_BITS-1], yin} - {y_q[COORD_BITS-1], y_q};

  // Radicand = (dx^2 + dy^2) << 2*FRAC_BITS
  logic [SQ_W-1:0]   sq_b;
  logic [SUM_W-1:0]  sq_sum;
  logic [RADP_W-1:0] rad_full;
  assign sq_b     = dy * dy;
  assign sq_sum   = SUM_W'(sq_a) + SUM_W'(sq_b);
  assign rad_full = RADP_W'(sq_sum) << (2 * FRAC_BITS);

  // One root bit per cycle
  logic [REM_W-1:0] rem_sh, trial;
  logic             take;
  logic [ROOT_W-1:0] root_nx;
  assign rem_sh  = {rem[REM_W-3:0], rad[RADL_W-1 -: 2]};
  assign trial   = REM_W'({root, 2'b01});
  assign take    = (rem_sh >= trial);
  assign root_nx = {root[ROOT_W-2:0], take};
  assign seg_wd  = ovf ? DIST_MAX : root_nx;

  // Walk evaluation
  logic [NW-1:0]     cp1;
  logic              at_end, last;
  logic [DIST_W-1:0] len;
  logic [DIST_W:0]   prog_sub, bp_sum, ob_sum;
  assign cp1      = NW'(cp) + NW'(1);
  assign at_end   = (cp1 >= n);
  assign last     = at_end || mk_q;
  assign len      = last ? '0 : seg_q;
  assign prog_sub = prog - {1'b0, len};
  assign bp_sum   = {1'b0, bp} + {1'b0, len};
  assign ob_sum   = {1'b0, sp} + {1'b0, bp};

  logic [DIST_W:0] tot_sum;
  assign tot_sum = {1'b0, total} + {1'b0, step_distance};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      cp        <= '0;
      cb        <= '0;
      sp        <= '0;
      bp        <= '0;
      total     <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            st    <= ST_OK;
            state <= S_FINISH;
            case (op)
              OP_LOAD: begin
                if (n < NW'(MAX_POINTS)) begin
                  xin      <= coord_x[COORD_BITS-1:0];
                  yin      <= coord_y[COORD_BITS-1:0];
                  seg_wa   <= n_dec[IW-1:0];
                  need_len <= (n != '0);
                  n        <= n + NW'(1);
                  state    <= S_LD_DIF;
                end else begin
                  st <= ST_TABLE_FULL;
                end
              end
              OP_START: begin
                cp    <= '0;
                cb    <= '0;
                sp    <= '0;
                bp    <= '0;
                total <= '0;
                done  <= 1'b0;
                if (n == '0) st <= ST_EMPTY;
              end
              OP_ADVANCE: begin
                if (n == '0) begin
                  st <= ST_EMPTY;
                end else if (done) begin
                  st <= ST_COMPLETE;
                end else begin
                  prog  <= {1'b0, sp} + {1'b0, step_distance};
                  total <= tot_sum[DIST_W] ? DIST_MAX : tot_sum[DIST_W-1:0];
                  state <= S_WK_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_DIF: begin
          // no segment when this is the first point or the previous one ends a block
          if (!need_len || mk_q) begin
            state <= S_FINISH;
          end else begin
            dx    <= dfx[DW-1] ? DW'(-dfx) : DW'(dfx);
            dy    <= dfy[DW-1] ? DW'(-dfy) : DW'(dfy);
            state <= S_LD_SQX;
          end
        end
        S_LD_SQX: begin
          sq_a  <= dx * dx;
          state <= S_LD_SQY;
        end
        S_LD_SQY: begin
          rad   <= rad_full[RADL_W-1:0];
          ovf   <= |rad_full[RADP_W-1:RADL_W];
          rem   <= '0;
          root  <= '0;
          iter  <= '0;
          state <= S_LD_ROOT;
        end
        S_LD_ROOT: begin
          rem  <= take ? (rem_sh - trial) : rem_sh;
          root <= root_nx;
          rad  <= {rad[RADL_W-3:0], 2'b00};
          iter <= iter + ITER_W'(1);
          if (seg_we) state <= S_FINISH;
        end
        S_WK_RD: begin
          state <= S_WK_EV;
        end
        S_WK_EV: begin
          if (prog >= {1'b0, len}) begin
            prog  <= prog_sub;
            state <= S_WK_RD;
            if (!last) begin
              bp <= bp_sum[DIST_W] ? DIST_MAX : bp_sum[DIST_W-1:0];
              cp <= cp1[IW-1:0];
            end else begin
              // step off the block end, skip the gap
              cb <= cb + IDX_OUT_W'(1);
              bp <= '0;
              if (at_end) begin
                done  <= 1'b1;
                sp    <= prog_sub[DIST_W] ? DIST_MAX : prog_sub[DIST_W-1:0];
                state <= S_FINISH;
              end else begin
                cp <= cp1[IW-1:0];
              end
            end
          end else begin
            sp    <= prog[DIST_W-1:0];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!out_valid || out_ready)) begin
      status        <= st;
      into_segment  <= sp;
      on_block      <= ob_sum[DIST_W] ? DIST_MAX : ob_sum[DIST_W-1:0];
      total_covered <= total;
      point_index   <= IDX_OUT_W'(cp);
      block_index   <= cb;
      complete      <= done;
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives loads, starts, advances and unused ops into the polyline walker with random
// sender gaps and receiver stalls, predicts every result item and compares
// each one field by field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]  status;
  logic [39:0] into_segment;
  logic [39:0] on_block;
  logic [39:0] total_covered;
  logic [9:0]  point_index;
  logic [9:0]  block_index;
  logic        complete;
} walk_result_t;

class walk_scoreboard;
  localparam int NPTS = pdw_pkg::MAX_POINTS_DEF;
  localparam logic [39:0] TOP40 = {40{1'b1}};

  logic signed [31:0] pt_x[NPTS];
  logic signed [31:0] pt_y[NPTS];
  bit                 pt_end[NPTS];
  logic [39:0]        pt_len[NPTS];
  int unsigned        loaded;
  int unsigned        cur_pt;
  logic [9:0]         cur_blk;
  logic [39:0]        seg_prog;
  logic [39:0]        blk_prog;
  logic [39:0]        walked;
  bit                 done;
  walk_result_t       pending[$];
  int                 errors;

  function new();
    loaded = 0;
    errors = 0;
    rewind();
  endfunction

  function void rewind();
    cur_pt   = 0;
    cur_blk  = '0;
    seg_prog = '0;
    blk_prog = '0;
    walked   = '0;
    done     = 0;
  endfunction

  function logic [39:0] sat40(logic [41:0] v);
    return (v > {2'b0, TOP40}) ? TOP40 : v[39:0];
  endfunction

  // floor(sqrt(dx^2+dy^2) * 2^FRAC), 40 result bits
  function logic [39:0] span(logic signed [31:0] x0, logic signed [31:0] y0,
                             logic signed [31:0] x1, logic signed [31:0] y1);
    logic signed [33:0] ddx, ddy;
    logic [127:0] ax, ay, acc, sq;
    logic [39:0] r, c;
    ddx = x1 - x0;
    ddy = y1 - y0;
    ax  = (ddx < 0) ? -ddx : ddx;
    ay  = (ddy < 0) ? -ddy : ddy;
    acc = (ax * ax + ay * ay) << (2 * pdw_pkg::FRAC_BITS_DEF);
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      c  = r | (40'd1 << b);
      sq = {88'b0, c} * {88'b0, c};
      if (sq <= acc) r = c;
    end
    return r;
  endfunction

  function bit at_last(int unsigned p);
    return (p + 1 >= loaded) || pt_end[p];
  endfunction

  function logic [39:0] len_at(int unsigned p);
    return at_last(p) ? 40'd0 : pt_len[p];
  endfunction

  function bit next_block();
    cur_blk  = cur_blk + 10'd1;
    blk_prog = '0;
    if (cur_pt + 1 >= loaded) begin
      done = 1;
      return 0;
    end
    cur_pt++;
    return 1;
  endfunction

  function bit next_point();
    if (!at_last(cur_pt)) begin
      blk_prog = sat40(blk_prog + pt_len[cur_pt]);
      cur_pt++;
      if (at_last(cur_pt)) return next_block();
      return 1;
    end
    return next_block();
  endfunction

  function void note_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                          bit eb, logic [39:0] step);
    walk_result_t e;
    logic [41:0] prog;
    logic [39:0] len;
    pdw_pkg::status_t st;
    st = pdw_pkg::ST_OK;
    case (pdw_pkg::op_t'(op))
      pdw_pkg::OP_LOAD: begin
        if (loaded >= NPTS) st = pdw_pkg::ST_TABLE_FULL;
        else begin
          pt_x[loaded]   = x;
          pt_y[loaded]   = y;
          pt_end[loaded] = eb;
          pt_len[loaded] = '0;
          if (loaded > 0 && !pt_end[loaded-1])
            pt_len[loaded-1] = span(pt_x[loaded-1], pt_y[loaded-1], x, y);
          loaded++;
        end
      end
      pdw_pkg::OP_START: begin
        rewind();
        if (loaded == 0) st = pdw_pkg::ST_EMPTY;
      end
      pdw_pkg::OP_ADVANCE: begin
        if (loaded == 0) st = pdw_pkg::ST_EMPTY;
        else if (done) st = pdw_pkg::ST_COMPLETE;
        else begin
          prog   = {2'b0, seg_prog} + step;
          len    = len_at(cur_pt);
          walked = sat40(walked + step);
          while (prog >= len) begin
            prog -= len;
            if (!next_point()) break;
            len = len_at(cur_pt);
          end
          seg_prog = sat40(prog);
        end
      end
      default: ;
    endcase
    e.status        = st;
    e.into_segment  = seg_prog;
    e.on_block      = sat40(seg_prog + blk_prog);
    e.total_covered = walked;
    e.point_index   = cur_pt[9:0];
    e.block_index   = cur_blk;
    e.complete      = done;
    pending.insert(pending.size(), e);
  endfunction

  function void check_result(walk_result_t got);
    walk_result_t e;
    logic [39:0] ev[7], av[7];
    string names[7] = '{"status", "into_segment", "on_block", "total_covered",
                        "point_index", "block_index", "complete"};
    if (pending.size() == 0) begin
      $display("%0t: result item with nothing expected", $realtime);
      errors++;
      return;
    end
    e  = pending.pop_front();
    ev = '{e.status, e.into_segment, e.on_block, e.total_covered,
           e.point_index, e.block_index, e.complete};
    av = '{got.status, got.into_segment, got.on_block, got.total_covered,
           got.point_index, got.block_index, got.complete};
    for (int i = 0; i < 7; i++)
      if (ev[i] !== av[i]) begin
        $display("%0t: %s expected %h actual %h", $realtime, names[i], ev[i], av[i]);
        errors++;
      end
  endfunction
endclass

module tb;
  import pdw_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic ends_block = 1'b0;
  logic [DIST_W-1:0] step_distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [DIST_W-1:0] into_segment, on_block, total_covered;
  logic [IDX_OUT_W-1:0] point_index, block_index;
  logic complete;

  walk_scoreboard sb = new();
  int  burst_left = 1;
  bit  sending = 0;
  int  cycles = 0;
  int  stall_mode = 0;
  logic signed [31:0] last_x = 0, last_y = 0;

  polyline_path_distance_walker_core uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_path_distance_walker_core: mismatch");
      $finish;
    end
  end

  // receiver: stall pattern is picked at random from four modes, switched periodically
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= cycles[0];
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, into_segment, on_block, total_covered,
                        point_index, block_index, complete});

  task automatic send(op_t o, logic signed [31:0] x, logic signed [31:0] y, bit eb,
                      logic [39:0] step);
    in_valid      <= 1'b1;
    op            <= o;
    coord_x       <= x;
    coord_y       <= y;
    ends_block    <= eb;
    step_distance <= step;
    sending = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(o, x, y, eb, step);
    if (--burst_left == 0) begin
      in_valid <= 1'b0;
      sending = 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 0;
      @(posedge clk);
    end
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_near(bit eb);
    logic signed [31:0] x, y;
    if ($urandom_range(0, 15) == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = last_x + $signed($urandom_range(0, 2000)) - 1000;
      y = last_y + $signed($urandom_range(0, 2000)) - 1000;
    end
    last_x = x;
    last_y = y;
    send(OP_LOAD, x, y, eb, 40'($urandom));
  endtask

  function automatic logic [39:0] rand_step();
    if ($urandom_range(0, 9) == 0) return 40'({$urandom, $urandom});
    return 40'($urandom_range(0, 1 << 20));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty path, unused op
    send(OP_START, 0, 0, 0, 0);
    send(OP_ADVANCE, 0, 0, 0, 40'd500);
    send(OP_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 1, 40'hFF_FFFF_FFFF);
    // extreme coordinates give a saturated length
    send(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send(OP_LOAD, 0, 0, 1, 0);
    send(OP_LOAD, 5, 5, 1, 0);             // single-point block
    send(OP_LOAD, 8, 9, 0, 0);
    send(OP_LOAD, 11, 13, 0, 0);
    send(OP_LOAD, 11, 13, 1, 0);           // zero-length segment
    send(OP_ADVANCE, 0, 0, 0, 40'd0);
    send(OP_ADVANCE, 0, 0, 0, 40'hFF_FFFF_FFFF);
    send(OP_ADVANCE, 0, 0, 0, 40'hFF_FFFF_FFFF);
    send(OP_ADVANCE, 0, 0, 0, 40'd300);
    send(OP_ADVANCE, 0, 0, 0, 40'd5000);
    send(OP_ADVANCE, 0, 0, 0, 40'hFF_FFFF_FFFF);
    send(OP_ADVANCE, 0, 0, 0, 40'd1);      // walk already complete
    send(OP_START, 0, 0, 0, 0);
    send(OP_ADVANCE, 0, 0, 0, 40'd1280);
    drain();

    for (int i = 0; i < 400; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) load_near($urandom_range(0, 4) == 0);
      else if (pick < 48)
        send(OP_START, $urandom, $urandom, 1'($urandom_range(0, 1)), rand_step());
      else if (pick < 51)
        send(OP_NONE, $urandom, $urandom, 1'($urandom_range(0, 1)), rand_step());
      else send(OP_ADVANCE, $urandom, $urandom, 1'($urandom_range(0, 1)), rand_step());
      if (i == 200) drain();
    end

    // walk the whole route from the start
    send(OP_START, 0, 0, 0, 0);
    repeat (20) send(OP_ADVANCE, 0, 0, 0, rand_step());
    repeat (3) send(OP_ADVANCE, 0, 0, 0, 40'hFF_FFFF_FFFF);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("polyline_path_distance_walker_core: match");
    else
      $display("polyline_path_distance_walker_core: mismatch");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/pdw_pkg.sv
hdl/polyline_path_distance_walker_core.sv
verif/tb.sv
